// ===== hw/rtl/control_message_deframer_macros.svh =====
// Assertion helpers used by the cmd_checker deframer checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef CONTROL_MESSAGE_DEFRAMER_MACROS_SVH
`define CONTROL_MESSAGE_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define CMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled at the rising clock edge outside reset.
`define CMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cmd_pkg.sv =====
package cmd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_HDR   = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_UNIT  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_IS_PLAYER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA_LEN  = 1'd1;

  localparam logic [15:0] MAX_DATA_LEN_RESET = 16'd1500;

  // Default depth of the queue between parser and result sequencer
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // One queued task: one to three results of the same kind
  typedef struct packed {
    logic [2:0]      kind;
    logic [2:0][7:0] data;   // data[0] goes out first
    logic [1:0]      cnt;    // number of results, 1 to 3
    logic            last;   // mark the final result of the task as last
  } task_t;

endpackage

// ===== hw/rtl/cmd_front.sv =====
module cmd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            unit_is_player,
  input  logic [15:0]     max_data_length,
  output logic            push,
  output cmd_pkg::task_t  push_task
);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  localparam logic [1:0] BAD_NONE  = 2'd0;
  localparam logic [1:0] BAD_START = 2'd1;
  localparam logic [1:0] BAD_UNIT  = 2'd2;

  localparam logic [3:0][7:0] MAGIC = {8'h50, 8'h43, 8'h53, 8'h49};

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_RECV   = 8'h31;
  localparam logic [7:0] CH_PLAYER = 8'h37;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_EOF    = 8'h1A;

  logic [1:0]      phase_r, phase_nxt;
  logic [1:0]      magic_cnt_r, magic_cnt_nxt;
  logic [3:0]      hdr_idx_r, hdr_idx_nxt;
  logic [31:0]     hdr_size_r, hdr_size_nxt;
  logic [31:0]     data_size_r, data_size_nxt;
  logic [7:0]      version_r, version_nxt;
  logic [15:0]     data_idx_r, data_idx_nxt;
  logic [1:0]      bad_r, bad_nxt;
  logic [2:0][7:0] hold_r, hold_nxt;
  logic [1:0]      hold_cnt_r, hold_cnt_nxt;

  logic [7:0]      unit_ch;
  logic [15:0]     size;
  logic            is_final;
  logic [2:0]      strip;
  logic [1:0]      keep;

  function automatic logic is_strip(input logic [7:0] b);
    is_strip = (b == CH_CR) || (b == CH_LF) || (b == CH_EOF);
  endfunction

  assign unit_ch  = unit_is_player ? CH_PLAYER : CH_RECV;
  // data size never exceeds the 16-bit limit once in the data phase
  assign size     = data_size_r[15:0];
  assign is_final = !(({1'b0, data_idx_r} + 17'd1) < {1'b0, size});

  // Parse one byte
  always_comb begin
    phase_nxt     = phase_r;
    magic_cnt_nxt = magic_cnt_r;
    hdr_idx_nxt   = hdr_idx_r;
    hdr_size_nxt  = hdr_size_r;
    data_size_nxt = data_size_r;
    version_nxt   = version_r;
    data_idx_nxt  = data_idx_r;
    bad_nxt       = bad_r;
    hold_nxt      = hold_r;
    hold_cnt_nxt  = hold_cnt_r;
    strip         = '0;
    keep          = 2'd0;
    push          = 1'b0;
    push_task     = '0;

    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_byte == MAGIC[magic_cnt_r]) begin
            if (magic_cnt_r == 2'd3) begin
              phase_nxt     = PH_HEADER;
              hdr_idx_nxt   = 4'd4;
              magic_cnt_nxt = 2'd0;
            end else begin
              magic_cnt_nxt = magic_cnt_r + 2'd1;
            end
          end else begin
            magic_cnt_nxt = (in_byte == MAGIC[0]) ? 2'd1 : 2'd0;
          end
        end

        PH_HEADER: begin
          if (hdr_idx_r < 4'd8) begin
            hdr_size_nxt = {hdr_size_r[23:0], in_byte};
          end else if (hdr_idx_r < 4'd12) begin
            data_size_nxt = {data_size_r[23:0], in_byte};
          end else if (hdr_idx_r == 4'd12) begin
            version_nxt = in_byte;
          end
          if (hdr_idx_r != 4'd15) begin
            hdr_idx_nxt = hdr_idx_r + 4'd1;
          end else begin
            priority if (hdr_size_r != 32'd16 || version_r != 8'd1 ||
                         data_size_r > {16'd0, max_data_length}) begin
              push           = 1'b1;
              push_task.kind = cmd_pkg::KIND_HDR;
              push_task.cnt  = 2'd1;
              push_task.last = 1'b1;
              phase_nxt      = PH_HUNT;
            end else if (data_size_r == 32'd0) begin
              push           = 1'b1;
              push_task.kind = cmd_pkg::KIND_START;
              push_task.cnt  = 2'd1;
              push_task.last = 1'b1;
              phase_nxt      = PH_HUNT;
            end else begin
              phase_nxt = PH_DATA;
            end
            magic_cnt_nxt = 2'd0;
            hdr_idx_nxt   = 4'd0;
            data_idx_nxt  = 16'd0;
            bad_nxt       = BAD_NONE;
            hold_cnt_nxt  = 2'd0;
          end
        end

        PH_DATA: begin
          // check start and unit characters, pass or hold payload
          if (data_idx_r == 16'd0) begin
            if (in_byte != CH_BANG) bad_nxt = BAD_START;
          end else if (data_idx_r == 16'd1) begin
            if (bad_r == BAD_NONE && in_byte != unit_ch) bad_nxt = BAD_UNIT;
          end else if (bad_r == BAD_NONE) begin
            if (({1'b0, data_idx_r} + 17'd3) < {1'b0, size}) begin
              push              = 1'b1;
              push_task.kind    = cmd_pkg::KIND_BYTE;
              push_task.data[0] = in_byte;
              push_task.cnt     = 2'd1;
              push_task.last    = 1'b0;
            end else if (hold_cnt_r != 2'd3) begin
              hold_nxt[hold_cnt_r] = in_byte;
              hold_cnt_nxt         = hold_cnt_r + 2'd1;
            end
          end

          if (!is_final) begin
            data_idx_nxt = data_idx_r + 16'd1;
          end else begin
            // close the message
            if (bad_nxt == BAD_NONE && size < 16'd2) bad_nxt = BAD_START;
            // count held bytes left after stripping trailing line ends
            for (int j = 0; j < 3; j++) begin
              strip[j] = is_strip(hold_nxt[j]);
            end
            unique case (hold_cnt_nxt)
              2'd3:    keep = !strip[2] ? 2'd3 : (!strip[1] ? 2'd2 : (!strip[0] ? 2'd1 : 2'd0));
              2'd2:    keep = !strip[1] ? 2'd2 : (!strip[0] ? 2'd1 : 2'd0);
              2'd1:    keep = !strip[0] ? 2'd1 : 2'd0;
              default: keep = 2'd0;
            endcase
            push           = 1'b1;
            push_task.last = 1'b1;
            priority if (bad_nxt != BAD_NONE) begin
              push_task.kind = (bad_nxt == BAD_START) ? cmd_pkg::KIND_START
                                                      : cmd_pkg::KIND_UNIT;
              push_task.cnt  = 2'd1;
            end else if (keep == 2'd0) begin
              push_task.kind = cmd_pkg::KIND_END;
              push_task.cnt  = 2'd1;
            end else begin
              push_task.kind = cmd_pkg::KIND_BYTE;
              push_task.cnt  = keep;
              for (int j = 0; j < 3; j++) begin
                push_task.data[j] = (2'(j) < keep) ? hold_nxt[j] : 8'd0;
              end
            end
            phase_nxt     = PH_HUNT;
            magic_cnt_nxt = 2'd0;
            hdr_idx_nxt   = 4'd0;
            data_idx_nxt  = 16'd0;
            bad_nxt       = BAD_NONE;
            hold_cnt_nxt  = 2'd0;
          end
        end

        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      magic_cnt_r <= 2'd0;
      hdr_idx_r   <= 4'd0;
      data_idx_r  <= 16'd0;
      bad_r       <= BAD_NONE;
      hold_cnt_r  <= 2'd0;
    end else begin
      phase_r     <= phase_nxt;
      magic_cnt_r <= magic_cnt_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      data_idx_r  <= data_idx_nxt;
      bad_r       <= bad_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
    end
  end

  // Header fields and held bytes
  always_ff @(posedge clk) begin
    hdr_size_r  <= hdr_size_nxt;
    data_size_r <= data_size_nxt;
    version_r   <= version_nxt;
    hold_r      <= hold_nxt;
  end

endmodule

// ===== hw/rtl/cmd_queue.sv =====
module cmd_queue #(
  parameter int unsigned DEPTH = cmd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cmd_pkg::task_t  push_task,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cmd_pkg::task_t  head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_pkg::task_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_task;
  end

endmodule

// ===== hw/rtl/cmd_back.sv =====
module cmd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  cmd_pkg::task_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic            out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r;
  logic [7:0] out_data_byte_r;
  logic       out_last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       at_end;

  // Load the output register whenever it is empty or being drained
  assign load   = head_valid && (!out_valid_r || out_ready);
  assign at_end = (idx_r == (head.cnt - 2'd1));
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r      <= head.kind;
      out_data_byte_r <= head.data[idx_r];
      out_last_r      <= head.last && at_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_byte_r;
  assign out_last      = out_last_r;

endmodule

// ===== hw/rtl/control_message_deframer.sv =====
// Control message deframer.
// Input: one stream byte per request on in_byte (in_valid/in_ready). The parser
// hunts for the "ISCP" magic, checks the 16-byte header and splits the data
// part into payload bytes with start and unit checks.
// Output: one result per request on out_kind/out_data_byte/out_last
// (out_valid/out_ready). Status results (header rejected, bad start, wrong
// unit) and message-end results always carry out_last.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// unit_is_player, index 1 is max_data_length. cfg_ready is always high.
// A byte's first result passes the queue and the output register before
// out_valid rises. Throughput: one byte per cycle while in_ready is high; the
// output sequencer gives one result per cycle while out_ready is high, and
// message ends with three results are absorbed by the QUEUE_DEPTH-entry queue
// between parser and sequencer. in_ready drops only while that queue is full.
// Reset (synchronous, rst_n low) returns to hunting, empties the queue and
// sets unit_is_player to 0 and max_data_length to 1500.
// When out_ready is low the output result holds, the queue fills, and then
// in_ready goes low until results drain.
module control_message_deframer #(
  parameter int unsigned QUEUE_DEPTH = cmd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_kind,
  output logic [7:0]                    out_data_byte,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  logic           unit_is_player_r;
  logic [15:0]    max_data_length_r;
  logic           q_full;
  logic           push;
  cmd_pkg::task_t push_task;
  logic           pop;
  logic           head_valid;
  cmd_pkg::task_t head;
  logic           accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_is_player_r  <= 1'b0;
      max_data_length_r <= cmd_pkg::MAX_DATA_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cmd_pkg::CFG_UNIT_IS_PLAYER: unit_is_player_r  <= cfg_data[0];
        cmd_pkg::CFG_MAX_DATA_LEN:   max_data_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_byte         (in_byte),
    .unit_is_player  (unit_is_player_r),
    .max_data_length (max_data_length_r),
    .push            (push),
    .push_task       (push_task)
  );

  cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_task  (push_task),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cmd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

endmodule

// ===== hw/rtl/cmd_checker.sv =====
`include "control_message_deframer_macros.svh"

module cmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic       out_last
);

  // Hold a stalled result
  `CMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data_byte) && $stable(out_last), "stalled result changed")

  // Status and end results close a message
  `CMD_ASSERT_NOW(a_status_last, out_valid && out_kind != cmd_pkg::KIND_BYTE, out_last, "status result without last")

  // Only payload results carry a byte
  `CMD_ASSERT_NOW(a_status_zero, out_valid && out_kind != cmd_pkg::KIND_BYTE, out_data_byte == 8'd0, "status result with nonzero byte")

  // Kind stays within the defined codes
  `CMD_ASSERT_NOW(a_kind_range, out_valid, out_kind <= cmd_pkg::KIND_UNIT, "undefined result kind")

endmodule

bind control_message_deframer cmd_checker u_cmd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_data_byte (out_data_byte),
  .out_last      (out_last)
);

// ===== bench/deframer_checker.sv =====
module deframer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [2:0]                    out_kind,
  input  logic [7:0]                    out_data_byte,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            owed_count,
  output int                            result_count
);

  localparam logic [31:0] MAGIC_WORD    = "ISCP";
  localparam logic [7:0]  BANG_CHAR     = 8'h21;
  localparam logic [7:0]  CR_CHAR       = 8'h0D;
  localparam logic [7:0]  LF_CHAR       = 8'h0A;
  localparam logic [7:0]  SUB_CHAR      = 8'h1A;
  localparam logic [7:0]  RECEIVER_UNIT = 8'h31;
  localparam logic [7:0]  PLAYER_UNIT   = 8'h37;

  localparam logic [1:0]  SEEK_MAGIC     = 2'd0;
  localparam logic [1:0]  TAKE_HEADER    = 2'd1;
  localparam logic [1:0]  TAKE_DATA      = 2'd2;

  localparam logic [1:0]  MSG_GOOD       = 2'd0;
  localparam logic [1:0]  MSG_BAD_START  = 2'd1;
  localparam logic [1:0]  MSG_WRONG_UNIT = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } deframed_t;

  // register copies
  logic         unit_player;
  logic [15:0]  max_len;

  // parser state
  logic [1:0]   phase;
  logic [1:0]   magic_hits;
  logic [3:0]   hdr_idx;
  logic [31:0]  hdr_size;
  logic [31:0]  data_size;
  logic [7:0]   version;
  logic [15:0]  data_idx;
  logic [1:0]   msg_status;
  logic [7:0]   held [3];
  logic [1:0]   held_n;

  deframed_t    owed [$];
  int           fails = 0;
  int           seen = 0;

  function automatic void owe(input logic [2:0] kind, input logic [7:0] data,
                              input logic last);
    owed.push_back({kind, data, last});
  endfunction

  function automatic void back_to_seek();
    phase      = SEEK_MAGIC;
    magic_hits = '0;
    hdr_idx    = '0;
    data_idx   = '0;
    msg_status = MSG_GOOD;
    held_n     = '0;
  endfunction

  // Advance the parser by one stream byte and queue the results it causes.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] unit_char;
    int         keep;
    case (phase)
      SEEK_MAGIC: begin
        if (b == MAGIC_WORD[(3 - int'(magic_hits)) * 8 +: 8]) begin
          if (magic_hits == 2'd3) begin
            phase      = TAKE_HEADER;
            hdr_idx    = 4'd4;
            magic_hits = '0;
          end else begin
            magic_hits++;
          end
        end else begin
          // a breaking byte may itself open a new match
          magic_hits = (b == MAGIC_WORD[31:24]) ? 2'd1 : 2'd0;
        end
      end
      TAKE_HEADER: begin
        if (hdr_idx < 4'd8) hdr_size = {hdr_size[23:0], b};
        else if (hdr_idx < 4'd12) data_size = {data_size[23:0], b};
        else if (hdr_idx == 4'd12) version = b;
        if (hdr_idx < 4'd15) begin
          hdr_idx++;
        end else if (hdr_size != 32'd16 || version != 8'd1 ||
                     data_size > 32'(max_len)) begin
          owe(cmd_pkg::KIND_HDR, 8'h00, 1'b1);
          back_to_seek();
        end else if (data_size == 32'd0) begin
          owe(cmd_pkg::KIND_START, 8'h00, 1'b1);
          back_to_seek();
        end else begin
          phase      = TAKE_DATA;
          hdr_idx    = '0;
          data_idx   = '0;
          msg_status = MSG_GOOD;
          held_n     = '0;
        end
      end
      default: begin
        unit_char = unit_player ? PLAYER_UNIT : RECEIVER_UNIT;
        if (data_idx == 16'd0) begin
          if (b != BANG_CHAR) msg_status = MSG_BAD_START;
        end else if (data_idx == 16'd1) begin
          if (msg_status == MSG_GOOD && b != unit_char) msg_status = MSG_WRONG_UNIT;
        end else if (msg_status == MSG_GOOD) begin
          // early payload goes straight out, the last three wait for trimming
          if (32'(data_idx) + 32'd3 < data_size) begin
            owe(cmd_pkg::KIND_BYTE, b, 1'b0);
          end else if (held_n < 2'd3) begin
            held[held_n] = b;
            held_n++;
          end
        end
        if (32'(data_idx) + 32'd1 < data_size) begin
          data_idx++;
        end else begin
          if (msg_status == MSG_GOOD && data_size < 32'd2) msg_status = MSG_BAD_START;
          if (msg_status != MSG_GOOD) begin
            owe((msg_status == MSG_BAD_START) ? cmd_pkg::KIND_START : cmd_pkg::KIND_UNIT,
                8'h00, 1'b1);
          end else begin
            // strip trailing CR, LF and end-of-file bytes from the held tail
            keep = int'(held_n);
            while (keep > 0 && (held[keep-1] == CR_CHAR || held[keep-1] == LF_CHAR ||
                                held[keep-1] == SUB_CHAR))
              keep--;
            if (keep == 0) begin
              owe(cmd_pkg::KIND_END, 8'h00, 1'b1);
            end else begin
              for (int k = 0; k < keep; k++)
                owe(cmd_pkg::KIND_BYTE, held[k], (k + 1 == keep));
            end
          end
          back_to_seek();
        end
      end
    endcase
  endfunction

  // Track writes and requests, compare each result with the oldest prediction.
  always @(posedge clk) begin
    deframed_t want;
    if (!rst_n) begin
      unit_player = 1'b0;
      max_len     = cmd_pkg::MAX_DATA_LEN_RESET;
      hdr_size    = '0;
      data_size   = '0;
      version     = '0;
      back_to_seek();
      owed.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cmd_pkg::CFG_UNIT_IS_PLAYER) unit_player = cfg_data[0];
        else if (cfg_index == cmd_pkg::CFG_MAX_DATA_LEN) max_len = cfg_data;
      end
      if (in_valid && in_ready) deframe_byte(in_byte);
      if (out_valid && out_ready) begin
        seen++;
        if (owed.size() == 0) begin
          fails++;
          $error("result with none expected: kind %0d data 0x%02h last %0b",
                 out_kind, out_data_byte, out_last);
        end else begin
          want = owed.pop_front();
          if (out_kind !== want.kind) begin
            fails++;
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
          end
          if (out_data_byte !== want.data) begin
            fails++;
            $error("out_data_byte: expected 0x%02h, actual 0x%02h", want.data, out_data_byte);
          end
          if (out_last !== want.last) begin
            fails++;
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
          end
        end
      end
    end
    fail_count   <= fails;
    owed_count   <= owed.size();
    result_count <= seen;
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;

  localparam int          HOLD_CYCLES   = 80;
  localparam int          QUIET_CYCLES  = 8;
  localparam logic [31:0] MAGIC_WORD    = "ISCP";
  localparam logic [7:0]  BANG_CHAR     = 8'h21;
  localparam logic [7:0]  CR_CHAR       = 8'h0D;
  localparam logic [7:0]  LF_CHAR       = 8'h0A;
  localparam logic [7:0]  SUB_CHAR      = 8'h1A;
  localparam logic [7:0]  RECEIVER_UNIT = 8'h31;
  localparam logic [7:0]  PLAYER_UNIT   = 8'h37;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    out_kind;
  logic [7:0]                    out_data_byte;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [cmd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;

  int                            fail_count;
  int                            owed_count;
  int                            result_count;

  // stimulus bookkeeping
  logic                          steady = 1'b0;
  int                            hold_seq = 0;
  logic [7:0]                    stream_q [$];
  int                            bytes_sent = 0;
  int                            frames = 0;
  int                            settings = 0;
  logic                          cur_unit = 1'b0;
  logic [15:0]                   cur_max = cmd_pkg::MAX_DATA_LEN_RESET;

  control_message_deframer u_dut (.*);

  deframer_checker u_checker (.*);

  always #2 clk = ~clk;

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != holds_taken) begin
        holds_taken = hold_seq;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flush_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Drop valid and wait until every predicted result has drained.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic unit, input logic [15:0] max_len);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= cmd_pkg::CFG_UNIT_IS_PLAYER;
    cfg_data  <= {15'd0, unit};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= cmd_pkg::CFG_MAX_DATA_LEN;
    cfg_data  <= max_len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_unit = unit;
    cur_max  = max_len;
    settings++;
  endtask

  // Queue the n low bytes of text, most significant first.
  function automatic void push_text(input logic [63:0] text, input int n);
    for (int i = n - 1; i >= 0; i--) stream_q.push_back(text[i*8 +: 8]);
  endfunction

  function automatic void push_header(input logic [31:0] hsize, input logic [31:0] dsize,
                                      input logic [7:0] ver);
    for (int i = 3; i >= 0; i--) stream_q.push_back(MAGIC_WORD[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) stream_q.push_back(hsize[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) stream_q.push_back(dsize[i*8 +: 8]);
    stream_q.push_back(ver);
    repeat (3) stream_q.push_back(8'($urandom_range(255)));
    frames++;
  endfunction

  // Message data with random payload, trailer bytes frequent near anywhere.
  function automatic void push_body(input int len, input bit start_ok, input bit unit_ok);
    logic [7:0] b;
    logic [7:0] unit_char;
    unit_char = cur_unit ? PLAYER_UNIT : RECEIVER_UNIT;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0) begin
        b = start_ok ? BANG_CHAR : ((b == BANG_CHAR) ? ~b : b);
      end else if (i == 1) begin
        b = unit_ok ? unit_char : ((b == unit_char) ? (b ^ 8'h06) : b);
      end else if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0:       b = CR_CHAR;
          1:       b = LF_CHAR;
          default: b = SUB_CHAR;
        endcase
      end
      stream_q.push_back(b);
    end
  endfunction

  // Mostly well-formed messages, the rest header faults, tiny sizes and noise.
  task automatic random_traffic(input int budget);
    int          start_count;
    int          pick;
    int          n;
    logic [31:0] hsize;
    logic [31:0] dsize;
    logic [7:0]  ver;
    start_count = bytes_sent;
    while (bytes_sent - start_count < budget) begin
      pick = $urandom_range(99);
      if (pick < 70 && cur_max >= 16'd2) begin
        dsize = 32'($urandom_range((cur_max < 16'd24) ? int'(cur_max) : 24, 2));
        push_header(32'd16, dsize, 8'd1);
        push_body(int'(dsize), $urandom_range(99) >= 8, $urandom_range(99) >= 12);
      end else if (pick < 82) begin
        hsize = 32'd16;
        ver   = 8'd1;
        dsize = 32'($urandom_range(8, 2));
        case ($urandom_range(2))
          0:       hsize = hsize ^ (32'd1 << $urandom_range(31));
          1:       ver = ver ^ (8'd1 << $urandom_range(7));
          default: dsize = (cur_max == 16'hFFFF) ? (32'h1_0000 << $urandom_range(15)) :
                           (32'(cur_max) + 32'($urandom_range(3, 1)));
        endcase
        push_header(hsize, dsize, ver);
      end else if (pick < 88) begin
        dsize = 32'($urandom_range(1));
        push_header(32'd16, dsize, 8'd1);
        if (dsize == 32'd1) push_text(64'($urandom), 1);
      end else if (pick < 94) begin
        n = $urandom_range(3, 1);
        push_text(64'(MAGIC_WORD >> (8 * (4 - n))), n);
        push_text(64'($urandom), 1);
      end else begin
        push_text({$urandom, $urandom}, $urandom_range(6, 1));
      end
      flush_stream();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // receiver unit, default limit, no idling on either side
    steady <= 1'b1;
    set_regs(1'b0, cmd_pkg::MAX_DATA_LEN_RESET);
    // broken and restarted magic, byte extremes, trailer byte inside the held tail stays
    push_text("ISCXI", 5);
    push_header(32'd16, 32'd8, 8'd1);
    push_text({"!1", 8'h00, 8'hFF, 8'h55, CR_CHAR, 8'hAA, LF_CHAR}, 8);
    // no payload
    push_header(32'd16, 32'd2, 8'd1);
    push_text("!1", 2);
    // header reject on version
    push_header(32'd16, 32'd4, 8'd2);
    // data size zero and one
    push_header(32'd16, 32'd0, 8'd1);
    push_header(32'd16, 32'd1, 8'd1);
    push_text("!", 1);
    // bad start hiding a wrong unit, wrong unit
    push_header(32'd16, 32'd4, 8'd1);
    push_text("?7xy", 4);
    push_header(32'd16, 32'd4, 8'd1);
    push_text("!7xy", 4);
    flush_stream();
    settle();
    steady <= 1'b0;

    // player unit, small limit: size over the limit, then hold the receiver
    // off during a message at the limit so the input stalls
    set_regs(1'b1, 16'd20);
    hold_seq <= hold_seq + 1;
    push_header(32'd16, 32'd21, 8'd1);
    push_header(32'd16, 32'd20, 8'd1);
    push_body(20, 1'b1, 1'b1);
    flush_stream();
    random_traffic(25);

    settle();
    $display("Covered %0d stream bytes in %0d headers over %0d register settings,",
             bytes_sent, frames, settings);
    $display("with %0d results checked against prediction.", result_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
